// ----- sv/complex_arithmetic_unit_defines.svh -----
// Assertion macros shared by the checker files of the complex arithmetic unit.
// Depends on nothing; the using module must have ports named clock and reset.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define CAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CAU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/cau_pkg.sv -----
// Package of the complex arithmetic unit: formats, opcodes and transaction types.
// Used by every module of the block; depends on nothing.
package cau_pkg;

   // Fixed point format of every operand and result part.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;

   // Magnitude of a sum of two products, and the dividend width of the divider.
   localparam int MAG_W   = 2 * DATA_W;
   localparam int DVD_W   = MAG_W + DATA_W;
   localparam int DIV_STEPS = DATA_W;

   // Opcodes.
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONJ = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r_re;
      logic signed [DATA_W-1:0] r_im;
      logic                     overflow;
      logic                     div_zero;
   } rsp_type;

   // Operands entering the divider pipeline.
   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [DATA_W-1:0] lo;
      logic [MAG_W-1:0]  den;
   } div_in_type;

   // Quotient and remainder leaving the divider pipeline.
   typedef struct packed {
      logic [DATA_W-1:0] quo;
      logic [MAG_W-1:0]  rem;
      logic [MAG_W-1:0]  den;
   } div_out_type;

endpackage

// ----- sv/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply, divide and conjugate on signed
// fixed point complex operands. It accepts one transaction every cycle unless the
// result side stalls, through a pipeline of input register, product, sum, magnitude,
// 32 divider stages, rounding and saturation; the divider resolves one quotient bit
// per stage. A stall on the result side holds the whole pipeline. Results round to
// nearest and saturate with a flag.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam logic [MAG_W:0] HALF = (65'd1 << FRAC_BITS) >> 1;

   // Sideband that travels next to the divider.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              neg_re;
      logic              neg_im;
      logic              big_re;
      logic              big_im;
      logic [DATA_W-1:0] fin_re;
      logic [DATA_W-1:0] fin_im;
      logic              fin_ov;
      logic              dz;
   } side_type;

   // Apply a sign to a magnitude and saturate; returns {overflow, value}.
   function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [MAG_W:0] mag);
      logic [MAG_W:0] lim;
      logic [MAG_W:0] m;
      logic           ov;
      lim = neg ? 65'h0_8000_0000 : 65'h0_7fff_ffff;
      ov  = mag > lim;
      m   = ov ? lim : mag;
      return {ov, neg ? (32'd0 - m[DATA_W-1:0]) : m[DATA_W-1:0]};
   endfunction

   // Saturate a 33-bit signed sum; returns {overflow, value}.
   function automatic logic [DATA_W:0] sat_sum(input logic signed [DATA_W:0] v);
      logic [DATA_W:0] m;
      m = v[DATA_W] ? 33'(-v) : 33'(v);
      return sat_mag(v[DATA_W], {32'd0, m});
   endfunction

   logic adv;

   // The pipeline moves unless a finished result waits on a stalled consumer.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Input register.
   logic    p0_valid_ff;
   req_type p0_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_req_ff <= req_data;
      end
   end

   // Products, and the results of the simple operations.
   logic signed [DATA_W:0]  ar33, ai33, br33, bi33;
   logic signed [DATA_W:0]  s_re, s_im;
   logic [DATA_W:0]         sat_re, sat_im;
   logic signed [MAG_W-1:0] pa_in, pb_in, pc_in, pd_in, pe_in, pf_in;

   assign ar33 = p0_req_ff.a_re;
   assign ai33 = p0_req_ff.a_im;
   assign br33 = p0_req_ff.b_re;
   assign bi33 = p0_req_ff.b_im;

   assign pa_in = p0_req_ff.a_re * p0_req_ff.b_re;
   assign pb_in = p0_req_ff.a_im * p0_req_ff.b_im;
   assign pc_in = p0_req_ff.a_re * p0_req_ff.b_im;
   assign pd_in = p0_req_ff.a_im * p0_req_ff.b_re;
   assign pe_in = p0_req_ff.b_re * p0_req_ff.b_re;
   assign pf_in = p0_req_ff.b_im * p0_req_ff.b_im;

   always_comb begin
      case (p0_req_ff.cmd)
         CMD_ADD: begin
            s_re = ar33 + br33;
            s_im = ai33 + bi33;
         end
         CMD_SUB: begin
            s_re = ar33 - br33;
            s_im = ai33 - bi33;
         end
         CMD_CONJ: begin
            s_re = ar33;
            s_im = -ai33;
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
   end

   assign sat_re = sat_sum(s_re);
   assign sat_im = sat_sum(s_im);

   logic                    p1_valid_ff;
   logic [CMD_W-1:0]        p1_cmd_ff;
   logic signed [MAG_W-1:0] p1_pa_ff, p1_pb_ff, p1_pc_ff, p1_pd_ff, p1_pe_ff, p1_pf_ff;
   logic [DATA_W-1:0]       p1_fin_re_ff, p1_fin_im_ff;
   logic                    p1_fin_ov_ff, p1_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= p0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_cmd_ff    <= p0_req_ff.cmd;
         p1_pa_ff     <= pa_in;
         p1_pb_ff     <= pb_in;
         p1_pc_ff     <= pc_in;
         p1_pd_ff     <= pd_in;
         p1_pe_ff     <= pe_in;
         p1_pf_ff     <= pf_in;
         p1_fin_re_ff <= sat_re[DATA_W-1:0];
         p1_fin_im_ff <= sat_im[DATA_W-1:0];
         p1_fin_ov_ff <= sat_re[DATA_W] | sat_im[DATA_W];
         p1_dz_ff     <= (p0_req_ff.cmd == CMD_DIV) && (p0_req_ff.b_re == '0)
                         && (p0_req_ff.b_im == '0);
      end
   end

   // Sums of products; divide uses the conjugate of the divisor.
   logic signed [MAG_W:0] sum_re_in, sum_im_in;
   logic [MAG_W-1:0]      den_in;

   always_comb begin
      case (p1_cmd_ff)
         CMD_MUL: begin
            sum_re_in = p1_pa_ff - p1_pb_ff;
            sum_im_in = p1_pc_ff + p1_pd_ff;
         end
         CMD_DIV: begin
            sum_re_in = p1_pa_ff + p1_pb_ff;
            sum_im_in = p1_pd_ff - p1_pc_ff;
         end
         default: begin
            sum_re_in = '0;
            sum_im_in = '0;
         end
      endcase
   end

   assign den_in = p1_pe_ff + p1_pf_ff;

   logic                  p2_valid_ff;
   logic [CMD_W-1:0]      p2_cmd_ff;
   logic signed [MAG_W:0] p2_sum_re_ff, p2_sum_im_ff;
   logic [MAG_W-1:0]      p2_den_ff;
   logic [DATA_W-1:0]     p2_fin_re_ff, p2_fin_im_ff;
   logic                  p2_fin_ov_ff, p2_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_cmd_ff    <= p1_cmd_ff;
         p2_sum_re_ff <= sum_re_in;
         p2_sum_im_ff <= sum_im_in;
         p2_den_ff    <= den_in;
         p2_fin_re_ff <= p1_fin_re_ff;
         p2_fin_im_ff <= p1_fin_im_ff;
         p2_fin_ov_ff <= p1_fin_ov_ff;
         p2_dz_ff     <= p1_dz_ff;
      end
   end

   // Sign and magnitude of each sum.
   logic [MAG_W:0] abs_re, abs_im;

   assign abs_re = p2_sum_re_ff[MAG_W] ? 65'(-p2_sum_re_ff) : 65'(p2_sum_re_ff);
   assign abs_im = p2_sum_im_ff[MAG_W] ? 65'(-p2_sum_im_ff) : 65'(p2_sum_im_ff);

   logic              p3_valid_ff;
   logic [CMD_W-1:0]  p3_cmd_ff;
   logic [MAG_W-1:0]  p3_mag_re_ff, p3_mag_im_ff, p3_den_ff;
   logic              p3_neg_re_ff, p3_neg_im_ff;
   logic [DATA_W-1:0] p3_fin_re_ff, p3_fin_im_ff;
   logic              p3_fin_ov_ff, p3_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_cmd_ff    <= p2_cmd_ff;
         p3_mag_re_ff <= abs_re[MAG_W-1:0];
         p3_mag_im_ff <= abs_im[MAG_W-1:0];
         p3_neg_re_ff <= p2_sum_re_ff[MAG_W];
         p3_neg_im_ff <= p2_sum_im_ff[MAG_W];
         p3_den_ff    <= p2_den_ff;
         p3_fin_re_ff <= p2_fin_re_ff;
         p3_fin_im_ff <= p2_fin_im_ff;
         p3_fin_ov_ff <= p2_fin_ov_ff;
         p3_dz_ff     <= p2_dz_ff;
      end
   end

   // Multiply rounding, and divider setup with an early check for quotients
   // too large for any result.
   logic [MAG_W:0]    rnd_re, rnd_im;
   logic [DATA_W:0]   mul_re, mul_im;
   logic [DVD_W-1:0]  dvd_re, dvd_im, den_top;
   side_type          side_in;
   div_in_type        div_re_in, div_im_in;
   div_out_type       div_re_out, div_im_out;

   assign rnd_re = ({1'b0, p3_mag_re_ff} + HALF) >> FRAC_BITS;
   assign rnd_im = ({1'b0, p3_mag_im_ff} + HALF) >> FRAC_BITS;
   assign mul_re = sat_mag(p3_neg_re_ff, rnd_re);
   assign mul_im = sat_mag(p3_neg_im_ff, rnd_im);

   assign dvd_re  = {32'd0, p3_mag_re_ff} << FRAC_BITS;
   assign dvd_im  = {32'd0, p3_mag_im_ff} << FRAC_BITS;
   assign den_top = {p3_den_ff, 32'd0};

   assign div_re_in = '{rem: dvd_re[DVD_W-1:DATA_W], lo: dvd_re[DATA_W-1:0], den: p3_den_ff};
   assign div_im_in = '{rem: dvd_im[DVD_W-1:DATA_W], lo: dvd_im[DATA_W-1:0], den: p3_den_ff};

   always_comb begin
      side_in.cmd    = p3_cmd_ff;
      side_in.neg_re = p3_neg_re_ff;
      side_in.neg_im = p3_neg_im_ff;
      side_in.big_re = dvd_re >= den_top;
      side_in.big_im = dvd_im >= den_top;
      side_in.dz     = p3_dz_ff;
      if (p3_cmd_ff == CMD_MUL) begin
         side_in.fin_re = mul_re[DATA_W-1:0];
         side_in.fin_im = mul_im[DATA_W-1:0];
         side_in.fin_ov = mul_re[DATA_W] | mul_im[DATA_W];
      end else begin
         side_in.fin_re = p3_fin_re_ff;
         side_in.fin_im = p3_fin_im_ff;
         side_in.fin_ov = p3_fin_ov_ff;
      end
   end

   cau_divider u_div_re (
      .clock (clock),
      .adv   (adv),
      .din   (div_re_in),
      .dout  (div_re_out)
   );

   cau_divider u_div_im (
      .clock (clock),
      .adv   (adv),
      .din   (div_im_in),
      .dout  (div_im_out)
   );

   // Sideband and valid bits alongside the divider stages.
   logic     dv_valid_ff [DIV_STEPS];
   side_type dv_side_ff  [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dv_valid_ff[0] <= p3_valid_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= side_in;
         for (int i = 1; i < DIV_STEPS; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
      end
   end

   // Round the quotients to nearest.
   logic [DATA_W:0] qr_re_in, qr_im_in;

   assign qr_re_in = {1'b0, div_re_out.quo}
                     + 33'({div_re_out.rem, 1'b0} >= {1'b0, div_re_out.den});
   assign qr_im_in = {1'b0, div_im_out.quo}
                     + 33'({div_im_out.rem, 1'b0} >= {1'b0, div_im_out.den});

   logic            r1_valid_ff;
   side_type        r1_side_ff;
   logic [DATA_W:0] r1_qr_re_ff, r1_qr_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
      end else if (adv) begin
         r1_valid_ff <= dv_valid_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_side_ff  <= dv_side_ff[DIV_STEPS-1];
         r1_qr_re_ff <= qr_re_in;
         r1_qr_im_ff <= qr_im_in;
      end
   end

   // Saturate the quotients and pick the result of the operation.
   logic [DATA_W:0] q_re, q_im;
   rsp_type         rsp_in;

   always_comb begin
      q_re = sat_mag(r1_side_ff.neg_re, {32'd0, r1_qr_re_ff});
      q_im = sat_mag(r1_side_ff.neg_im, {32'd0, r1_qr_im_ff});
      if (r1_side_ff.big_re) begin
         q_re = {1'b1, r1_side_ff.neg_re ? 32'h8000_0000 : 32'h7fff_ffff};
      end
      if (r1_side_ff.big_im) begin
         q_im = {1'b1, r1_side_ff.neg_im ? 32'h8000_0000 : 32'h7fff_ffff};
      end
      if (r1_side_ff.cmd == CMD_DIV) begin
         if (r1_side_ff.dz) begin
            rsp_in = '{r_re: '0, r_im: '0, overflow: 1'b0, div_zero: 1'b1};
         end else begin
            rsp_in.r_re     = q_re[DATA_W-1:0];
            rsp_in.r_im     = q_im[DATA_W-1:0];
            rsp_in.overflow = q_re[DATA_W] | q_im[DATA_W];
            rsp_in.div_zero = 1'b0;
         end
      end else begin
         rsp_in.r_re     = r1_side_ff.fin_re;
         rsp_in.r_im     = r1_side_ff.fin_im;
         rsp_in.overflow = r1_side_ff.fin_ov;
         rsp_in.div_zero = 1'b0;
      end
   end

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/cau_divider.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on cau_pkg.
module cau_divider (
   input  logic               clock,
   input  logic               adv,
   input  cau_pkg::div_in_type  din,
   output cau_pkg::div_out_type dout
);
   import cau_pkg::*;

   logic [MAG_W-1:0]  rem_ff [DIV_STEPS];
   logic [MAG_W-1:0]  rem_in [DIV_STEPS];
   logic [DATA_W-1:0] lo_ff  [DIV_STEPS];
   logic [DATA_W-1:0] lo_in  [DIV_STEPS];
   logic [MAG_W-1:0]  den_ff [DIV_STEPS];
   logic [MAG_W-1:0]  den_in [DIV_STEPS];
   logic [DATA_W-1:0] quo_ff [DIV_STEPS];
   logic [DATA_W-1:0] quo_in [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [MAG_W-1:0]  rem_src;
      logic [DATA_W-1:0] lo_src;
      logic [MAG_W-1:0]  den_src;
      logic [DATA_W-1:0] quo_src;
      logic [MAG_W:0]    trial;
      logic [MAG_W:0]    diff;
      logic              ge;

      // The first stage takes the new operands, later ones the stage before.
      if (i == 0) begin : g_first
         assign rem_src = din.rem;
         assign lo_src  = din.lo;
         assign den_src = din.den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign lo_src  = lo_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end

      // Bring down the next dividend bit and subtract the divisor if it fits.
      assign trial = {rem_src, lo_src[DATA_W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign ge    = trial >= {1'b0, den_src};

      assign rem_in[i] = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      assign lo_in[i]  = {lo_src[DATA_W-2:0], 1'b0};
      assign den_in[i] = den_src;
      assign quo_in[i] = {quo_src[DATA_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= rem_in[i];
            lo_ff[i]  <= lo_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign dout.quo = quo_ff[DIV_STEPS-1];
   assign dout.rem = rem_ff[DIV_STEPS-1];
   assign dout.den = den_ff[DIV_STEPS-1];

endmodule

// ----- sv/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit, bound to its top level.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
`include "complex_arithmetic_unit_defines.svh"

module cau_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   // A stalled result transaction holds.
   `CAU_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // A full output stage stalls the input side.
   `CAU_ASSERT(a_backpressure, rsp_valid && rsp_stall |-> req_stall, "input accepted while output stalled")

   // A zero divisor gives a clean zero result.
   `CAU_ASSERT(a_div_zero, rsp_valid && rsp_data.div_zero |-> rsp_data.r_re == '0 && rsp_data.r_im == '0 && !rsp_data.overflow, "zero divisor result not zero")

   // Reset empties the pipeline.
   `CAU_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_checker (.*);

// ----- tb/complex_arithmetic_unit_tb.sv -----
// Self-checking testbench of the complex arithmetic unit: directed and random transactions
// are checked against a fixed point predictor of add, subtract, multiply, divide and conjugate.
// Depends on cau_pkg and the complex_arithmetic_unit module.
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int WIDE = 128;
   localparam int DRAIN_CYCLES = 60;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_results[$];
   int      error_count;
   bit      sender_idles;
   bit      receiver_stalls;

   complex_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Clock with a period of two time units.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Saturate a wide signed value to the 32-bit result range.
   function automatic logic [DATA_W-1:0] saturate(input logic signed [WIDE-1:0] v,
                                                  inout logic ov);
      if (v > 128'sh7FFFFFFF) begin
         ov = 1'b1;
         return 32'h7FFFFFFF;
      end
      if (v < -128'sh80000000) begin
         ov = 1'b1;
         return 32'h80000000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Round a product sum with 2*FRAC_BITS fraction bits, ties away from zero.
   function automatic logic signed [WIDE-1:0] round_product(input logic signed [WIDE-1:0] s);
      logic [WIDE-1:0] mag;
      mag = (s < 0) ? -s : s;
      mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (s < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   // Round n * 2^FRAC_BITS / d to nearest, ties away from zero, for d > 0.
   function automatic logic signed [WIDE-1:0] round_quotient(input logic signed [WIDE-1:0] n,
                                                            input logic [WIDE-1:0] d);
      logic [WIDE-1:0] mag;
      logic [WIDE-1:0] quo;
      logic [WIDE-1:0] rem;
      mag = (n < 0) ? -n : n;
      mag = mag << FRAC_BITS;
      quo = mag / d;
      rem = mag % d;
      if (2 * rem >= d)
         quo = quo + 1;
      return (n < 0) ? -$signed(quo) : $signed(quo);
   endfunction

   // Expected result of one complex operation.
   function automatic rsp_type complex_result(input req_type t);
      rsp_type r;
      logic ov;
      logic signed [WIDE-1:0] ar, ai, br, bi, den;
      r = '0;
      ov = 1'b0;
      ar = t.a_re;
      ai = t.a_im;
      br = t.b_re;
      bi = t.b_im;
      case (t.cmd)
         CMD_ADD: begin
            r.r_re = saturate(ar + br, ov);
            r.r_im = saturate(ai + bi, ov);
         end
         CMD_SUB: begin
            r.r_re = saturate(ar - br, ov);
            r.r_im = saturate(ai - bi, ov);
         end
         CMD_MUL: begin
            r.r_re = saturate(round_product(ar * br - ai * bi), ov);
            r.r_im = saturate(round_product(ar * bi + ai * br), ov);
         end
         CMD_DIV: begin
            if (br == 0 && bi == 0) begin
               r.div_zero = 1'b1;
            end else begin
               den = br * br + bi * bi;
               r.r_re = saturate(round_quotient(ar * br + ai * bi, den), ov);
               r.r_im = saturate(round_quotient(ai * br - ar * bi, den), ov);
            end
         end
         CMD_CONJ: begin
            r.r_re = saturate(ar, ov);
            r.r_im = saturate(-ai, ov);
         end
         default: begin
         end
      endcase
      r.overflow = ov;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Record the expected result of every accepted transaction.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_results.push_back(complex_result(req_data));
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.r_re !== e.r_re)
               report_mismatch($sformatf("r_re %h, expected %h", rsp_data.r_re, e.r_re));
            if (rsp_data.r_im !== e.r_im)
               report_mismatch($sformatf("r_im %h, expected %h", rsp_data.r_im, e.r_im));
            if (rsp_data.overflow !== e.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_data.overflow, e.overflow));
            if (rsp_data.div_zero !== e.div_zero)
               report_mismatch($sformatf("div_zero %b, expected %b",
                                         rsp_data.div_zero, e.div_zero));
         end
      end
   end

   // Random stall of the result channel.
   always @(posedge clock) begin
      rsp_stall <= receiver_stalls && ($urandom_range(0, 99) < 13);
   end

   // Send one transaction, with an occasional one-cycle idle gap before it.
   task automatic send_operands(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] a_re,
                                input logic [DATA_W-1:0] a_im, input logic [DATA_W-1:0] b_re,
                                input logic [DATA_W-1:0] b_im);
      req_type t;
      t.cmd = cmd;
      t.a_re = a_re;
      t.a_im = a_im;
      t.b_re = b_re;
      t.b_im = b_im;
      if (sender_idles && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Operand part drawn from extremes, small values and the full range.
   function automatic logic [DATA_W-1:0] random_part();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return $urandom_range(0, 2) - 1;
         3, 4: return $urandom_range(0, 1 << 19) - (1 << 18);
         5: return $urandom_range(0, 1 << 25) - (1 << 24);
         default: return $urandom;
      endcase
   endfunction

   // Extremes of the fields, every operation and each special case.
   task automatic test_directed();
      send_operands(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
      send_operands(CMD_ADD, 32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h00008000);
      send_operands(CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
      send_operands(CMD_SUB, 32'h00030000, 32'h00000000, 32'h00010000, 32'h00010000);
      send_operands(CMD_MUL, 32'h00010000, 32'h00010000, 32'h00010000, 32'hFFFF0000);
      send_operands(CMD_MUL, 32'h00000001, 32'h00000000, 32'h00008000, 32'h00000000);
      send_operands(CMD_MUL, 32'hFFFFFFFF, 32'h00000000, 32'h00008000, 32'h00000000);
      send_operands(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_operands(CMD_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      send_operands(CMD_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
      send_operands(CMD_DIV, 32'h00010000, 32'h00000000, 32'h00000001, 32'h00000000);
      send_operands(CMD_DIV, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00010000);
      send_operands(CMD_DIV, 32'h00010000, 32'h00000000, 32'h00030000, 32'h00000000);
      send_operands(CMD_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_operands(CMD_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
      send_operands(CMD_CONJ, 32'h12345678, 32'h80000000, 32'h0, 32'h0);
      send_operands(CMD_CONJ, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_operands(3'd5, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
      send_operands(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_operands(3'd7, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
      end_burst();
   endtask

   // Random operations, mostly legal opcodes; idling off for a long stretch.
   task automatic test_random(input int count);
      logic [CMD_W-1:0] cmd;
      for (int i = 0; i < count; i++) begin
         sender_idles = !(i >= count / 3 && i < count / 2);
         receiver_stalls = sender_idles;
         cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         send_operands(cmd, random_part(), random_part(), random_part(), random_part());
      end
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      end_burst();
   endtask

   // Let the pipeline drain completely before sending more.
   task automatic wait_for_results();
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_drained_restart();
      wait_for_results();
      for (int i = 0; i < 40; i++)
         send_operands(3'($urandom_range(0, 4)), random_part(), random_part(),
                       random_part(), random_part());
      end_burst();
   endtask

   initial begin
      error_count = 0;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(1000);
      test_drained_restart();
      test_random(1000);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Timeout well above the slowest correct run.
   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cau_pkg.sv
sv/cau_divider.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
